@@ sv/jsu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the JSON string unescaper.
// No dependencies; used by every module of the block.
package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_NO_QUOTE    = 4'd1;
    localparam logic [3:0] ERR_CONTROL     = 4'd2;
    localparam logic [3:0] ERR_BAD_ESCAPE  = 4'd3;
    localparam logic [3:0] ERR_BAD_HEX     = 4'd4;
    localparam logic [3:0] ERR_MISSING_LO  = 4'd5;
    localparam logic [3:0] ERR_LO_RANGE    = 4'd6;
    localparam logic [3:0] ERR_LONE_LO     = 4'd7;
    localparam logic [3:0] ERR_UNTERMINATED = 4'd8;

    // All results caused by one input byte
    typedef struct packed {
        logic [1:0]      last_idx;   // number of results minus one
        logic [3:0][7:0] bytes;      // result bytes, zero for close or error
        logic [1:0]      kind;
        logic [3:0]      err;
    } group_t;

    // Group plus its valid flag, as it moves between front, queue and back
    typedef struct packed {
        logic   valid;
        group_t grp;
    } group_req_t;

endpackage

@@ sv/json_string_unescaper.sv @@
`timescale 1ns / 1ps
// Top level of the JSON string unescaper: front decoder, group queue and
// output serializer. Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back.
//
//  channel  | direction | tdata                          | tuser     | tlast
//  ---------+-----------+--------------------------------+-----------+-----------
//  s_axis   | in        | [7:0] in_byte                  | [0] input_end | unused
//  m_axis   | out       | [7:0] out_byte, [11:8] error_code | [1:0] kind | last_of_run
//
// The front end takes one request per cycle and decodes it in that cycle;
// s_axis_tready drops only while the group queue is full.
// The back end sends one result per cycle while m_axis_tready allows it;
// a request expands to up to four results (four for a surrogate pair).
// Output register decouples m_axis_tready from the front end; reset clears
// the phase and empties the queue, no warm-up cycles needed.
module json_string_unescaper
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_axis_tuser,   // [0] input_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] error_code
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last_of_run
);

    jsu_pkg::group_req_t push;
    jsu_pkg::group_req_t head;
    logic                q_full;
    logic                pop;
    logic                accept;
    logic [7:0]          o_byte;
    logic [3:0]          o_err;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    jsu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (s_axis_tdata),
        .input_end (s_axis_tuser[0]),
        .push      (push)
    );

    jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (q_full)
    );

    jsu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_byte  (o_byte),
        .out_kind  (m_axis_tuser),
        .out_err   (o_err),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, o_err, o_byte};

`ifndef SYNTHESIS
    // close and error always end the run of their request
    a_term_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != jsu_pkg::KIND_BYTE |-> m_axis_tlast)
        else $error("close or error result without tlast");

    // decoded bytes carry no error code, errors and closes carry no byte
    a_field_split: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == jsu_pkg::KIND_BYTE) ?
            (m_axis_tdata[15:8] == 8'd0) : (m_axis_tdata[7:0] == 8'd0))
        else $error("result fields mixed up");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == jsu_pkg::KIND_ERROR |->
            m_axis_tdata[11:8] != jsu_pkg::ERR_NONE)
        else $error("error result without an error code");

    // backpressure only comes from a full queue, which must hold a group
    a_stall_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> head.valid)
        else $error("input stalled with an empty queue");
`endif

endmodule

@@ sv/jsu_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts text bytes, tracks the string/escape phase and turns
// each byte into a group of zero to four results. Depends on jsu_pkg.
module jsu_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                input_end,
    output jsu_pkg::group_req_t push
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_STR   = 3'd1;
    localparam logic [2:0] PH_ESC   = 3'd2;
    localparam logic [2:0] PH_HEX   = 3'd3;
    localparam logic [2:0] PH_BSL   = 3'd4;
    localparam logic [2:0] PH_U     = 3'd5;
    localparam logic [2:0] PH_HEXLO = 3'd6;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] accum_reg, accum_next;
    logic [9:0]  hs_reg, hs_next;
    logic [1:0]  cnt_reg, cnt_next;

    logic        dig_ok;
    logic [3:0]  dig_val;
    logic [15:0] acc_new;
    logic        fourth;
    logic        is_hi;
    logic        is_lo;
    logic [10:0] hs_plus;
    jsu_pkg::group_t grp;
    logic        has_res;

    function automatic jsu_pkg::group_t one_result(input logic [7:0] b,
                                                   input logic [1:0] k,
                                                   input logic [3:0] e);
        jsu_pkg::group_t g;
        g          = '0;
        g.bytes[0] = b;
        g.kind     = k;
        g.err      = e;
        return g;
    endfunction

    function automatic jsu_pkg::group_t utf8_group(input logic [20:0] cp);
        jsu_pkg::group_t g;
        g      = '0;
        g.kind = jsu_pkg::KIND_BYTE;
        if (cp <= 21'h7F)
        begin
            g.bytes[0] = cp[7:0];
        end
        else if (cp <= 21'h7FF)
        begin
            g.last_idx = 2'd1;
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp <= 21'hFFFF)
        begin
            g.last_idx = 2'd2;
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            g.last_idx = 2'd3;
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
        end
        return g;
    endfunction

    always_comb
    begin
        dig_ok  = 1'b1;
        dig_val = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            dig_val = in_byte[3:0];
        else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46))
            dig_val = in_byte[3:0] + 4'd9;
        else
            dig_ok = 1'b0;
    end

    assign acc_new = {accum_reg[11:0], dig_val};
    assign fourth  = (cnt_reg == 2'd3);
    assign is_hi   = (acc_new >= 16'hD800) && (acc_new <= 16'hDBFF);
    assign is_lo   = (acc_new >= 16'hDC00) && (acc_new <= 16'hDFFF);
    // plane offset of the pair: high bits plus 0x10000 >> 10
    assign hs_plus = {1'b0, hs_reg} + 11'd64;

    always_comb
    begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        hs_next    = hs_reg;
        cnt_next   = cnt_reg;
        grp        = '0;
        has_res    = 1'b0;

        case (phase_reg)
            PH_STR:
            begin
                if (input_end)
                begin
                    grp = one_result(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERMINATED);
                    has_res = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    grp = one_result(8'd0, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE);
                    has_res = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (in_byte < CH_SPACE)
                begin
                    grp = one_result(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_CONTROL);
                    has_res = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (in_byte == CH_BSL)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    grp = one_result(in_byte, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
                    has_res = 1'b1;
                end
            end

            PH_ESC:
            begin
                has_res    = 1'b1;
                phase_next = PH_STR;
                if (input_end)
                begin
                    grp = one_result(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERMINATED);
                    phase_next = PH_IDLE;
                end
                else
                begin
                    case (in_byte)
                        CH_QUOTE: grp = one_result(CH_QUOTE, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
                        CH_BSL:   grp = one_result(CH_BSL, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
                        CH_SLASH: grp = one_result(CH_SLASH, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
                        CH_B:     grp = one_result(CH_BS, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
                        CH_F:     grp = one_result(CH_FF, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
                        CH_N:     grp = one_result(CH_LF, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
                        CH_R:     grp = one_result(CH_CR, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
                        CH_T:     grp = one_result(CH_TAB, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
                        CH_U:
                        begin
                            has_res    = 1'b0;
                            phase_next = PH_HEX;
                            accum_next = '0;
                            cnt_next   = '0;
                        end
                        default:
                        begin
                            grp = one_result(8'd0, jsu_pkg::KIND_ERROR,
                                             jsu_pkg::ERR_BAD_ESCAPE);
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end

            PH_HEX, PH_HEXLO:
            begin
                if (input_end)
                begin
                    grp = one_result(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERMINATED);
                    has_res = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (!dig_ok)
                begin
                    grp = one_result(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_HEX);
                    has_res = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    accum_next = acc_new;
                    cnt_next   = cnt_reg + 2'd1;
                    if (fourth)
                    begin
                        has_res = 1'b1;
                        if (phase_reg == PH_HEX)
                        begin
                            if (is_hi)
                            begin
                                // hold the high half and expect \u next
                                has_res    = 1'b0;
                                hs_next    = acc_new[9:0];
                                phase_next = PH_BSL;
                            end
                            else if (is_lo)
                            begin
                                grp = one_result(8'd0, jsu_pkg::KIND_ERROR,
                                                 jsu_pkg::ERR_LONE_LO);
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                grp = utf8_group({5'd0, acc_new});
                                phase_next = PH_STR;
                            end
                        end
                        else if (!is_lo)
                        begin
                            grp = one_result(8'd0, jsu_pkg::KIND_ERROR,
                                             jsu_pkg::ERR_LO_RANGE);
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            grp = utf8_group({hs_plus, acc_new[9:0]});
                            phase_next = PH_STR;
                        end
                    end
                end
            end

            PH_BSL:
            begin
                if (input_end || in_byte != CH_BSL)
                begin
                    grp = one_result(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_MISSING_LO);
                    has_res = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_U;
                end
            end

            PH_U:
            begin
                if (input_end || in_byte != CH_U)
                begin
                    grp = one_result(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_MISSING_LO);
                    has_res = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_HEXLO;
                    accum_next = '0;
                    cnt_next   = '0;
                end
            end

            default:
            begin
                // idle: skip whitespace, wait for the opening quote
                phase_next = PH_IDLE;
                if (!input_end && (in_byte == CH_SPACE || in_byte == CH_TAB ||
                                   in_byte == CH_LF || in_byte == CH_CR))
                begin
                    has_res = 1'b0;
                end
                else if (!input_end && in_byte == CH_QUOTE)
                begin
                    phase_next = PH_STR;
                end
                else
                begin
                    grp = one_result(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_NO_QUOTE);
                    has_res = 1'b1;
                end
            end
        endcase
    end

    assign push.valid = accept && has_res;
    assign push.grp   = grp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            accum_reg <= '0;
            hs_reg    <= '0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            hs_reg    <= hs_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ sv/jsu_queue.sv @@
`timescale 1ns / 1ps
// Short FIFO of result groups between the front and back ends.
// Depends on jsu_pkg.
module jsu_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  jsu_pkg::group_req_t push,
    input  logic                pop,
    output jsu_pkg::group_req_t head,
    output logic                full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    jsu_pkg::group_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head.valid = (count_reg != '0);
    assign head.grp   = slot_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push.grp;
    end

endmodule

@@ sv/jsu_back.sv @@
`timescale 1ns / 1ps
// Back end: walks the head group into the output register one result
// per cycle unless stalled; pops it after the last. Depends on jsu_pkg.
module jsu_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  jsu_pkg::group_req_t head,
    output logic                pop,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    output logic [1:0]          out_kind,
    output logic [3:0]          out_err,
    output logic                out_last
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic [1:0] kind_reg;
    logic [3:0] err_reg;
    logic       last_reg;
    logic       load;
    logic       at_last;

    assign load    = head.valid && (!valid_reg || out_ready);
    assign at_last = (idx_reg == head.grp.last_idx);
    assign pop     = load && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.grp.bytes[idx_reg];
            kind_reg <= head.grp.kind;
            err_reg  <= head.grp.err;
            last_reg <= at_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_kind  = kind_reg;
    assign out_err   = err_reg;
    assign out_last  = last_reg;

endmodule
